@@ rtl/ace_pkg.sv @@
package ace_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);

    // slot states
    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_PEND = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    // functions
    localparam logic [1:0] FN_RESOLVE = 2'd0;
    localparam logic [1:0] FN_PACKET  = 2'd1;
    localparam logic [1:0] FN_SWEEP   = 2'd2;
    localparam logic [1:0] FN_TIMEOUT = 2'd3;

    // result kinds
    localparam logic [2:0] K_ANSWER = 3'd0;
    localparam logic [2:0] K_SENDRQ = 3'd1;
    localparam logic [2:0] K_REPLY  = 3'd2;
    localparam logic [2:0] K_WAKE   = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;

    // status codes
    localparam logic [2:0] S_OK       = 3'd0;
    localparam logic [2:0] S_ERROR    = 3'd1;
    localparam logic [2:0] S_TIMEOUT  = 3'd2;
    localparam logic [2:0] S_OVERFLOW = 3'd3;
    localparam logic [2:0] S_IGNORED  = 3'd4;

    // config register indexes
    localparam logic [2:0] R_OWN_IP    = 3'd0;
    localparam logic [2:0] R_OWN_MAC   = 3'd1;
    localparam logic [2:0] R_BCAST_MAC = 3'd2;
    localparam logic [2:0] R_SUBNET_BC = 3'd3;
    localparam logic [2:0] R_IP_VALID  = 3'd4;
    localparam logic [2:0] R_AGE_LIMIT = 3'd5;
    localparam logic [2:0] R_RETRY_LIM = 3'd6;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
        logic [7:0]  waiter;
        logic [3:0]  tries;
    } entry_t;

    localparam entry_t ENTRY_ZERO = '0;

    // per-cycle write command from the controller to the last cell, which takes the head entry
    typedef struct packed {
        logic        wr;
        entry_t      data;
    } cell_cmd_t;

endpackage

@@ rtl/arp_cache_engine.sv @@
// Channel   Dir  Handshake        Payload
// in        in   in_valid/stall   func, query_ip .. now_time
// out       out  out_valid/stall  kind, status, mac_addr, target_ip, waiter, last
// cfg       in   cfg_valid/ready  cfg_index, cfg_data
//
// Each item takes one ring rotation that scans the slots (a sweep also wipes
// stale slots in it) and a second that writes at most one planned slot, then
// its results are emitted. Reset clears all slots at once. The input is
// stalled while an item is in flight; a stalled result holds until taken.
module arp_cache_engine
    import ace_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   func,
    input  logic [31:0]  query_ip,
    input  logic [7:0]   requester,
    input  logic [15:0]  hw_type,
    input  logic [15:0]  proto_type,
    input  logic [15:0]  opcode,
    input  logic [31:0]  sender_ip,
    input  logic [47:0]  sender_mac,
    input  logic [31:0]  dest_ip,
    input  logic [31:0]  now_time,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   kind,
    output logic [2:0]   status,
    output logic [47:0]  mac_addr,
    output logic [31:0]  target_ip,
    output logic [7:0]   waiter,
    output logic         last
);

    logic [31:0] own_ip_reg, subnet_bc_reg, age_limit_reg;
    logic [47:0] own_mac_reg, bcast_mac_reg;
    logic        ip_valid_reg;
    logic [3:0]  retry_reg;

    entry_t    ent [ENTRIES];
    logic      rotate;
    cell_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg    <= '0;
            own_mac_reg   <= '0;
            bcast_mac_reg <= '1;
            subnet_bc_reg <= '1;
            ip_valid_reg  <= 1'b0;
            age_limit_reg <= 32'd300;
            retry_reg     <= 4'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                R_OWN_IP:    own_ip_reg    <= cfg_data[31:0];
                R_OWN_MAC:   own_mac_reg   <= cfg_data;
                R_BCAST_MAC: bcast_mac_reg <= cfg_data;
                R_SUBNET_BC: subnet_bc_reg <= cfg_data[31:0];
                R_IP_VALID:  ip_valid_reg  <= cfg_data[0];
                R_AGE_LIMIT: age_limit_reg <= cfg_data[31:0];
                R_RETRY_LIM: retry_reg     <= cfg_data[3:0];
                default:     own_mac_reg   <= own_mac_reg;
            endcase
        end
    end

    // ring: cell i takes from cell i+1, last cell takes the head (cell 0)
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            ace_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .rotate     (rotate),
                .load       ((g == ENTRIES - 1) && cmd.wr),
                .load_entry (cmd.data),
                .prev_entry (ent[(g + 1) % ENTRIES]),
                .entry      (ent[g])
            );
        end
    endgenerate

    ace_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .query_ip        (query_ip),
        .requester       (requester),
        .hw_type         (hw_type),
        .proto_type      (proto_type),
        .opcode          (opcode),
        .sender_ip       (sender_ip),
        .sender_mac      (sender_mac),
        .dest_ip         (dest_ip),
        .now_time        (now_time),
        .own_ip          (own_ip_reg),
        .bcast_mac       (bcast_mac_reg),
        .subnet_bcast_ip (subnet_bc_reg),
        .ip_valid        (ip_valid_reg),
        .age_limit       (age_limit_reg),
        .retry_limit     (retry_reg),
        .head            (ent[0]),
        .rotate          (rotate),
        .cmd             (cmd),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .status          (status),
        .mac_addr        (mac_addr),
        .target_ip       (target_ip),
        .waiter          (waiter),
        .last            (last)
    );

endmodule

@@ rtl/ace_cell.sv @@
// One slot of the ring. Every rotate cycle it takes its neighbor's entry;
// the last cell instead may take the controller's rewritten head entry.
module ace_cell
    import ace_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   rotate,
    input  logic   load,
    input  entry_t load_entry,
    input  entry_t prev_entry,
    output entry_t entry
);

    entry_t entry_reg;

    // state field needs reset; payload cleared too so freed slots read zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_ZERO;
        end
        else if (rotate)
        begin
            entry_reg <= load ? load_entry : prev_entry;
        end
    end

    assign entry = entry_reg;

endmodule

@@ rtl/ace_ctrl.sv @@
// Sequencer: two full ring rotations per item. Pass 1 scans (lookup,
// first free, first resolved, sweep); pass 2 applies the planned write, if any.
module ace_ctrl
    import ace_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   func,
    input  logic [31:0]  query_ip,
    input  logic [7:0]   requester,
    input  logic [15:0]  hw_type,
    input  logic [15:0]  proto_type,
    input  logic [15:0]  opcode,
    input  logic [31:0]  sender_ip,
    input  logic [47:0]  sender_mac,
    input  logic [31:0]  dest_ip,
    input  logic [31:0]  now_time,
    // config
    input  logic [31:0]  own_ip,
    input  logic [47:0]  bcast_mac,
    input  logic [31:0]  subnet_bcast_ip,
    input  logic         ip_valid,
    input  logic [31:0]  age_limit,
    input  logic [3:0]   retry_limit,
    // ring head
    input  entry_t       head,
    output logic         rotate,
    output cell_cmd_t    cmd,
    // result channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   kind,
    output logic [2:0]   status,
    output logic [47:0]  mac_addr,
    output logic [31:0]  target_ip,
    output logic [7:0]   waiter,
    output logic         last
);

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        SCAN  = 5'b00010,
        APPLY = 5'b00100,
        EMIT0 = 5'b01000,
        EMIT1 = 5'b10000
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    // latched request
    logic [1:0]  fn_reg;
    logic [31:0] qip_reg, sip_reg, now_reg, key_reg;
    logic [7:0]  req_reg;
    logic [47:0] smac_reg;
    logic        pkt_ok_reg, for_us_reg;

    // scan results
    logic [SLOT_W-1:0] pos_reg;
    logic              hit_reg, free_f_reg, res_f_reg;
    logic [SLOT_W-1:0] hit_reg_idx, free_idx_reg, res_idx_reg;
    entry_t            hit_e_reg;

    // planned write and results
    logic              wr_en_reg;
    logic [SLOT_W-1:0] wr_idx_reg;
    entry_t            wr_e_reg;
    logic [2:0]        r0_kind_reg, r0_st_reg, r1_kind_reg, r1_st_reg;
    logic [47:0]       r0_mac_reg, r1_mac_reg;
    logic [31:0]       r0_ip_reg, r1_ip_reg;
    logic [7:0]        r0_w_reg, r1_w_reg;
    logic              two_reg;

    logic [31:0] age;
    logic        stale;
    logic        last_pos;

    assign age      = now_reg - head.stamp;
    assign stale    = (fn_reg == FN_SWEEP) && (head.state == ST_RES) && (age > age_limit);
    assign last_pos = (pos_reg == SLOT_W'(ENTRIES - 1));

    assign in_stall = (fsm_reg != IDLE);
    assign rotate   = (fsm_reg == SCAN) || (fsm_reg == APPLY);

    // ring write: sweep wipes in scan pass, planned write in apply pass
    always_comb
    begin
        cmd.wr   = 1'b0;
        cmd.data = head;
        if (fsm_reg == SCAN && stale)
        begin
            cmd.wr   = 1'b1;
            cmd.data = ENTRY_ZERO;
        end
        else if (fsm_reg == APPLY && wr_en_reg && pos_reg == wr_idx_reg)
        begin
            cmd.wr   = 1'b1;
            cmd.data = wr_e_reg;
        end
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            IDLE:    if (in_valid) fsm_next = SCAN;
            SCAN:    if (last_pos) fsm_next = APPLY;
            APPLY:   if (last_pos) fsm_next = EMIT0;
            EMIT0:   if (!out_stall) fsm_next = two_reg ? EMIT1 : IDLE;
            EMIT1:   if (!out_stall) fsm_next = IDLE;
            default: fsm_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= IDLE;
        end
        else
        begin
            fsm_reg <= fsm_next;
        end
    end

    // request latched in idle; scan results and the decision made at the end of the scan pass
    always_ff @(posedge clk)
    begin
        logic              hit, ff, rf;
        logic [SLOT_W-1:0] hi, fi, ri;
        entry_t            he, ne;
        logic              alloc_ok;
        logic [SLOT_W-1:0] alloc_idx;
        hit = hit_reg; ff = free_f_reg; rf = res_f_reg;
        hi = hit_reg_idx; fi = free_idx_reg; ri = res_idx_reg; he = hit_e_reg;
        ne = ENTRY_ZERO;
        alloc_ok  = 1'b0;
        alloc_idx = '0;
        case (fsm_reg)
            IDLE:
            begin
                pos_reg    <= '0;
                hit_reg    <= 1'b0;
                free_f_reg <= 1'b0;
                res_f_reg  <= 1'b0;
                fn_reg     <= func;
                qip_reg    <= query_ip;
                req_reg    <= requester;
                sip_reg    <= sender_ip;
                smac_reg   <= sender_mac;
                now_reg    <= now_time;
                key_reg    <= (func == FN_PACKET) ? sender_ip : query_ip;
                pkt_ok_reg <= (hw_type == 16'd1) && (proto_type == 16'h0800);
                for_us_reg <= ip_valid && (dest_ip == own_ip) && (opcode != 16'd2);
            end
            SCAN:
            begin
                pos_reg <= pos_reg + 1'b1;
                if (!hit && head.state != ST_FREE && head.ip == key_reg)
                begin
                    hit = 1'b1; hi = pos_reg; he = head;
                end
                if (!ff && (head.state == ST_FREE || stale))
                begin
                    ff = 1'b1; fi = pos_reg;
                end
                if (!rf && head.state == ST_RES)
                begin
                    rf = 1'b1; ri = pos_reg;
                end
                hit_reg <= hit; hit_reg_idx <= hi; hit_e_reg <= he;
                free_f_reg <= ff; free_idx_reg <= fi;
                res_f_reg <= rf; res_idx_reg <= ri;
                if (last_pos)
                begin
                    alloc_ok  = ff || rf;
                    alloc_idx = ff ? fi : ri;
                    wr_en_reg  <= 1'b0;
                    wr_idx_reg <= hi;
                    two_reg    <= 1'b0;
                    r0_mac_reg <= '0; r0_ip_reg <= '0; r0_w_reg <= '0;
                    r1_mac_reg <= '0; r1_ip_reg <= '0; r1_w_reg <= '0;
                    r0_st_reg  <= S_OK;
                    r1_st_reg  <= S_OK;
                    case (fn_reg)
                        FN_RESOLVE:
                        begin
                            r0_kind_reg <= K_ANSWER;
                            if (qip_reg == 32'hFFFF_FFFF || qip_reg == subnet_bcast_ip)
                            begin
                                r0_mac_reg <= bcast_mac;
                            end
                            else if (hit && he.state == ST_RES)
                            begin
                                ne = he; ne.stamp = now_reg;
                                wr_en_reg <= 1'b1; wr_e_reg <= ne;
                                r0_mac_reg <= he.mac;
                            end
                            else if (hit)
                            begin
                                r0_st_reg <= S_ERROR;
                            end
                            else if (!alloc_ok)
                            begin
                                r0_st_reg <= S_OVERFLOW;
                            end
                            else
                            begin
                                ne.state = ST_PEND; ne.ip = qip_reg;
                                ne.waiter = req_reg; ne.tries = 4'd1;
                                wr_en_reg <= 1'b1; wr_idx_reg <= alloc_idx; wr_e_reg <= ne;
                                r0_kind_reg <= K_SENDRQ; r0_ip_reg <= qip_reg;
                            end
                        end
                        FN_PACKET:
                        begin
                            r0_kind_reg <= K_DONE;
                            if (!pkt_ok_reg)
                            begin
                                r0_st_reg <= S_IGNORED;
                            end
                            else
                            begin
                                if (hit)
                                begin
                                    ne = he; ne.mac = smac_reg;
                                    if (he.state == ST_PEND)
                                    begin
                                        ne.state = ST_RES; ne.stamp = now_reg;
                                    end
                                    wr_en_reg <= 1'b1; wr_e_reg <= ne;
                                end
                                else if (for_us_reg && alloc_ok)
                                begin
                                    ne.state = ST_RES; ne.ip = sip_reg;
                                    ne.mac = smac_reg; ne.stamp = now_reg;
                                    wr_en_reg <= 1'b1; wr_idx_reg <= alloc_idx;
                                    wr_e_reg <= ne;
                                end
                                // final result goes to slot 1 if a wake precedes it
                                if (hit && he.state == ST_PEND)
                                begin
                                    two_reg <= 1'b1;
                                    r0_kind_reg <= K_WAKE; r0_mac_reg <= smac_reg;
                                    r0_ip_reg <= sip_reg; r0_w_reg <= he.waiter;
                                    r1_kind_reg <= for_us_reg ? K_REPLY : K_DONE;
                                    if (for_us_reg)
                                    begin
                                        r1_mac_reg <= smac_reg; r1_ip_reg <= sip_reg;
                                    end
                                end
                                else if (!for_us_reg)
                                begin
                                    r0_kind_reg <= K_DONE;
                                end
                                else if (!hit && !alloc_ok)
                                begin
                                    r0_st_reg <= S_OVERFLOW;
                                end
                                else
                                begin
                                    r0_kind_reg <= K_REPLY;
                                    r0_mac_reg <= smac_reg; r0_ip_reg <= sip_reg;
                                end
                            end
                        end
                        FN_SWEEP:
                        begin
                            r0_kind_reg <= K_DONE;
                        end
                        default:
                        begin
                            if (!hit || he.state != ST_PEND)
                            begin
                                r0_kind_reg <= K_DONE; r0_st_reg <= S_IGNORED;
                            end
                            else if (he.tries < retry_limit)
                            begin
                                ne = he; ne.tries = he.tries + 4'd1;
                                wr_en_reg <= 1'b1; wr_e_reg <= ne;
                                r0_kind_reg <= K_SENDRQ; r0_ip_reg <= qip_reg;
                            end
                            else
                            begin
                                wr_en_reg <= 1'b1; wr_e_reg <= ENTRY_ZERO;
                                r0_kind_reg <= K_WAKE; r0_st_reg <= S_TIMEOUT;
                                r0_ip_reg <= qip_reg; r0_w_reg <= he.waiter;
                            end
                        end
                    endcase
                end
            end
            APPLY:
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // result channel
    assign out_valid = (fsm_reg == EMIT0) || (fsm_reg == EMIT1);
    always_comb
    begin
        if (fsm_reg == EMIT1)
        begin
            kind = r1_kind_reg; status = r1_st_reg; mac_addr = r1_mac_reg;
            target_ip = r1_ip_reg; waiter = r1_w_reg; last = 1'b1;
        end
        else
        begin
            kind = r0_kind_reg; status = r0_st_reg; mac_addr = r0_mac_reg;
            target_ip = r0_ip_reg; waiter = r0_w_reg; last = !two_reg;
        end
    end

endmodule

@@ rtl/ace_checker.sv @@
module ace_checker
    import ace_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [2:0] status,
    input logic       last
);

    // no result while the block is free for a new request
    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result while input open");

    // accepted request blocks the next one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held after accept");

    // a wake that is not final is followed only by a final result
    a_two: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> (out_valid && last))
        else $error("missing final result");

    // non-final results are always ok wakes
    a_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (kind == K_WAKE && status == S_OK))
        else $error("bad non-final result");

    // stalled result keeps its kind
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind)))
        else $error("stalled result changed");

endmodule

bind arp_cache_engine ace_checker u_ace_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .status    (status),
    .last      (last)
);

@@ tb/arp_cache_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, config and result channels of arp_cache_engine, keeps
// its own copy of the cache and registers, and checks every result in order.
module arp_cache_checker
    import ace_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_stall,
    input  logic [1:0]   func,
    input  logic [31:0]  query_ip,
    input  logic [7:0]   requester,
    input  logic [15:0]  hw_type,
    input  logic [15:0]  proto_type,
    input  logic [15:0]  opcode,
    input  logic [31:0]  sender_ip,
    input  logic [47:0]  sender_mac,
    input  logic [31:0]  dest_ip,
    input  logic [31:0]  now_time,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         out_valid,
    input  logic         out_stall,
    input  logic [2:0]   kind,
    input  logic [2:0]   status,
    input  logic [47:0]  mac_addr,
    input  logic [31:0]  target_ip,
    input  logic [7:0]   waiter,
    input  logic         last,
    output int           fails,
    output int           pending
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [47:0] mac;
        logic [31:0] tip;
        logic [7:0]  wtr;
        logic        last;
    } result_t;

    result_t     due_q[$];
    result_t     got, want;

    // cache copy
    logic [1:0]  e_st    [ENTRIES];
    logic [31:0] e_ip    [ENTRIES];
    logic [47:0] e_mac   [ENTRIES];
    logic [31:0] e_stamp [ENTRIES];
    logic [7:0]  e_wtr   [ENTRIES];
    logic [3:0]  e_tries [ENTRIES];

    // register copy (own MAC feeds no result)
    logic [31:0] c_own_ip;
    logic [47:0] c_bcast_mac;
    logic [31:0] c_subnet;
    logic        c_ip_valid;
    logic [31:0] c_age;
    logic [3:0]  c_retry;

    task automatic post(input logic [2:0] k, input logic [2:0] st, input logic [47:0] mac,
                        input logic [31:0] tip, input logic [7:0] w, input logic lst);
        result_t r;
        r = '{k, st, mac, tip, w, lst};
        due_q.push_back(r);
    endtask

    task automatic clear_slot(input int s);
        e_st[s]    = ST_FREE;
        e_ip[s]    = '0;
        e_mac[s]   = '0;
        e_stamp[s] = '0;
        e_wtr[s]   = '0;
        e_tries[s] = '0;
    endtask

    function automatic int find_slot(input logic [31:0] ip);
        for (int s = 0; s < ENTRIES; s++)
            if (e_st[s] != ST_FREE && e_ip[s] == ip)
                return s;
        return -1;
    endfunction

    // lowest free slot, else evict lowest resolved slot, else -1
    task automatic claim_slot(output int s);
        s = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (e_st[i] == ST_RES)
                s = i;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (e_st[i] == ST_FREE)
                s = i;
        if (s >= 0)
            clear_slot(s);
    endtask

    task automatic predict_request();
        int s;
        case (func)
            FN_RESOLVE:
            begin
                if (query_ip == 32'hFFFF_FFFF || query_ip == c_subnet)
                    post(K_ANSWER, S_OK, c_bcast_mac, '0, '0, 1'b1);
                else
                begin
                    s = find_slot(query_ip);
                    if (s >= 0 && e_st[s] == ST_RES)
                    begin
                        e_stamp[s] = now_time;
                        post(K_ANSWER, S_OK, e_mac[s], '0, '0, 1'b1);
                    end
                    else if (s >= 0)
                        post(K_ANSWER, S_ERROR, '0, '0, '0, 1'b1);
                    else
                    begin
                        claim_slot(s);
                        if (s < 0)
                            post(K_ANSWER, S_OVERFLOW, '0, '0, '0, 1'b1);
                        else
                        begin
                            e_st[s]    = ST_PEND;
                            e_ip[s]    = query_ip;
                            e_wtr[s]   = requester;
                            e_tries[s] = 4'd1;
                            post(K_SENDRQ, S_OK, '0, query_ip, '0, 1'b1);
                        end
                    end
                end
            end
            FN_PACKET:
            begin
                if (hw_type != 16'd1 || proto_type != 16'h0800)
                    post(K_DONE, S_IGNORED, '0, '0, '0, 1'b1);
                else
                begin
                    s = find_slot(sender_ip);
                    if (s >= 0)
                    begin
                        e_mac[s] = sender_mac;
                        if (e_st[s] == ST_PEND)
                        begin
                            e_st[s]    = ST_RES;
                            e_stamp[s] = now_time;
                            post(K_WAKE, S_OK, sender_mac, sender_ip, e_wtr[s], 1'b0);
                        end
                    end
                    if (!c_ip_valid || dest_ip != c_own_ip || opcode == 16'd2)
                        post(K_DONE, S_OK, '0, '0, '0, 1'b1);
                    else if (s >= 0)
                        post(K_REPLY, S_OK, sender_mac, sender_ip, '0, 1'b1);
                    else
                    begin
                        claim_slot(s);
                        if (s < 0)
                            post(K_DONE, S_OVERFLOW, '0, '0, '0, 1'b1);
                        else
                        begin
                            e_st[s]    = ST_RES;
                            e_ip[s]    = sender_ip;
                            e_mac[s]   = sender_mac;
                            e_stamp[s] = now_time;
                            post(K_REPLY, S_OK, sender_mac, sender_ip, '0, 1'b1);
                        end
                    end
                end
            end
            FN_SWEEP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (e_st[i] == ST_RES && 32'(now_time - e_stamp[i]) > c_age)
                        clear_slot(i);
                post(K_DONE, S_OK, '0, '0, '0, 1'b1);
            end
            default:
            begin
                s = find_slot(query_ip);
                if (s < 0 || e_st[s] != ST_PEND)
                    post(K_DONE, S_IGNORED, '0, '0, '0, 1'b1);
                else if (e_tries[s] < c_retry)
                begin
                    e_tries[s] = e_tries[s] + 4'd1;
                    post(K_SENDRQ, S_OK, '0, query_ip, '0, 1'b1);
                end
                else
                begin
                    post(K_WAKE, S_TIMEOUT, '0, query_ip, e_wtr[s], 1'b1);
                    clear_slot(s);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                clear_slot(i);
            c_own_ip    = '0;
            c_bcast_mac = 48'hFFFF_FFFF_FFFF;
            c_subnet    = 32'hFFFF_FFFF;
            c_ip_valid  = 1'b0;
            c_age       = 32'd300;
            c_retry     = 4'd3;
            due_q.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            // result check against oldest expectation
            if (out_valid && !out_stall)
            begin
                got = '{kind, status, mac_addr, target_ip, waiter, last};
                if (due_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result kind=%0d status=%0d mac=%h ip=%h w=%0d last=%0b",
                                 $time, kind, status, mac_addr, target_ip, waiter, last);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch exp kind=%0d st=%0d mac=%h ip=%h w=%0d last=%0b / got kind=%0d st=%0d mac=%h ip=%h w=%0d last=%0b",
                                     $time, want.kind, want.status, want.mac, want.tip, want.wtr,
                                     want.last, got.kind, got.status, got.mac, got.tip, got.wtr,
                                     got.last);
                    end
                end
            end
            // register writes
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    R_OWN_IP:    c_own_ip    = cfg_data[31:0];
                    R_BCAST_MAC: c_bcast_mac = cfg_data;
                    R_SUBNET_BC: c_subnet    = cfg_data[31:0];
                    R_IP_VALID:  c_ip_valid  = cfg_data[0];
                    R_AGE_LIMIT: c_age       = cfg_data[31:0];
                    R_RETRY_LIM: c_retry     = cfg_data[3:0];
                    default: ;
                endcase
            // accepted request
            if (in_valid && !in_stall)
                predict_request();
            pending = due_q.size();
        end
    end

endmodule

@@ tb/tb_arp_cache_engine.sv @@
`timescale 1ns / 100ps

module tb_arp_cache_engine;
    import ace_pkg::*;

    localparam int RUN_LIMIT = 3_000_000;
    localparam int PER_PHASE = 270;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [1:0]   func = '0;
    logic [31:0]  query_ip = '0;
    logic [7:0]   requester = '0;
    logic [15:0]  hw_type = '0;
    logic [15:0]  proto_type = '0;
    logic [15:0]  opcode = '0;
    logic [31:0]  sender_ip = '0;
    logic [47:0]  sender_mac = '0;
    logic [31:0]  dest_ip = '0;
    logic [31:0]  now_time = '0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [47:0]  cfg_data = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [2:0]   kind;
    logic [2:0]   status;
    logic [47:0]  mac_addr;
    logic [31:0]  target_ip;
    logic [7:0]   waiter;
    logic         last;
    int           fails;
    int           pending;

    typedef struct {
        logic [1:0]  fn;
        logic [31:0] qip;
        logic [7:0]  req;
        logic [15:0] hw;
        logic [15:0] pt;
        logic [15:0] op;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] dip;
        logic [31:0] now;
    } arp_event_t;

    arp_cache_engine i_dut (.*);
    arp_cache_checker i_chk (.*);

    always #5 clk = ~clk;

    // handshake seen at the last rising edge
    logic in_fire = 1'b0, cfg_fire = 1'b0;
    always @(posedge clk)
    begin
        in_fire  <= in_valid && !in_stall;
        cfg_fire <= cfg_valid && cfg_ready;
    end

    // receiver stall
    int stall_pct = 0;
    int idle_pct  = 0;
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    logic [31:0] ip_pool [24];
    logic [31:0] my_ip;
    logic [31:0] subnet_ip = 32'hFFFF_FFFF;
    logic [31:0] clock_s;

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic arp_event_t mk_event(input logic [1:0] fn, input logic [31:0] qip,
                                            input logic [15:0] op, input logic [31:0] sip,
                                            input logic [31:0] dip, input logic [31:0] now);
        arp_event_t e;
        e = '{fn, qip, 8'($urandom), 16'd1, 16'h0800, op, sip, rand48(), dip, now};
        return e;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_fire)
            @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == R_OWN_IP)
            my_ip = val[31:0];
        if (idx == R_SUBNET_BC)
            subnet_ip = val[31:0];
        @(negedge clk);
    endtask

    // drive one request, hold until taken, then maybe idle
    task automatic send_request(input arp_event_t e);
        in_valid   <= 1'b1;
        func       <= e.fn;
        query_ip   <= e.qip;
        requester  <= e.req;
        hw_type    <= e.hw;
        proto_type <= e.pt;
        opcode     <= e.op;
        sender_ip  <= e.sip;
        sender_mac <= e.smac;
        dest_ip    <= e.dip;
        now_time   <= e.now;
        @(negedge clk);
        while (!in_fire)
            @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return ip_pool[$urandom_range(23)];
        else if (r < 90)
            return $urandom;
        else if (r < 95)
            return 32'hFFFF_FFFF;
        return subnet_ip;
    endfunction

    task automatic rand_request(output arp_event_t e);
        int r;
        r = $urandom_range(99);
        if ($urandom_range(19) == 0)
            clock_s = $urandom;
        else
            clock_s = clock_s + $urandom_range(0, 40);
        e = mk_event(FN_RESOLVE, pick_ip(), 16'd1, pick_ip(), my_ip, clock_s);
        if (r < 35)
            e.fn = FN_RESOLVE;
        else if (r < 70)
        begin
            e.fn = FN_PACKET;
            r = $urandom_range(99);
            e.op = (r < 45) ? 16'd1 : (r < 80) ? 16'd2 : 16'($urandom);
            if ($urandom_range(99) < 30)
                e.dip = $urandom_range(1) ? 32'($urandom) : my_ip ^ 32'(1 << $urandom_range(31));
            if ($urandom_range(99) < 12)
            begin
                e.hw = $urandom_range(1) ? 16'($urandom) : 16'd1;
                e.pt = $urandom_range(1) ? 16'($urandom) : 16'h0800;
            end
        end
        else if (r < 80)
            e.fn = FN_SWEEP;
        else
            e.fn = FN_TIMEOUT;
        if ($urandom_range(9) == 0)
        begin
            e.hw = 16'($urandom);
            e.pt = 16'($urandom);
            e.op = 16'($urandom);
            e.sip = $urandom;
            e.dip = $urandom;
        end
    endtask

    initial
    begin
        arp_event_t ev;
        for (int i = 0; i < 24; i++)
            ip_pool[i] = {27'($urandom), 5'(i)};
        my_ip   = 32'd0;
        clock_s = $urandom;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset configuration, no own address
        send_request(mk_event(FN_RESOLVE, 32'hFFFF_FFFF, 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_RESOLVE, ip_pool[0], 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_RESOLVE, ip_pool[0], 16'd1, '0, '0, clock_s));
        repeat (3)
            send_request(mk_event(FN_TIMEOUT, ip_pool[0], 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_TIMEOUT, ip_pool[1], 16'd1, '0, '0, clock_s));
        ev = mk_event(FN_PACKET, '0, 16'd1, ip_pool[2], '0, clock_s);
        ev.hw = 16'hFFFF;
        ev.pt = 16'h0000;
        send_request(ev);
        send_request(mk_event(FN_PACKET, '0, 16'd1, ip_pool[2], '0, clock_s));
        drain();

        // directed: own address assigned
        cfg_write(R_OWN_IP, {16'h0, ip_pool[23]});
        cfg_write(R_IP_VALID, 48'd1);
        cfg_write(R_SUBNET_BC, {16'h0, 32'($urandom)});
        send_request(mk_event(FN_RESOLVE, subnet_ip, 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_RESOLVE, ip_pool[3], 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_PACKET, '0, 16'd2, ip_pool[3], my_ip, clock_s));
        send_request(mk_event(FN_RESOLVE, ip_pool[3], 16'd1, '0, '0, clock_s + 5));
        send_request(mk_event(FN_PACKET, '0, 16'd1, ip_pool[4], my_ip, clock_s));
        send_request(mk_event(FN_PACKET, '0, 16'hFFFF, ip_pool[4], my_ip, clock_s));
        send_request(mk_event(FN_SWEEP, '0, 16'd1, '0, '0, clock_s + 1000));
        // fill every slot with pending entries, then overflow both ways
        for (int i = 5; i < 21; i++)
            send_request(mk_event(FN_RESOLVE, ip_pool[i], 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_RESOLVE, ip_pool[21], 16'd1, '0, '0, clock_s));
        send_request(mk_event(FN_PACKET, '0, 16'd1, ip_pool[22], my_ip, clock_s));
        drain();

        // random phases, each with its own settings and one of four idling modes
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    cfg_write(R_RETRY_LIM, 48'd1);
                    cfg_write(R_AGE_LIMIT, 48'd0);
                    cfg_write(R_BCAST_MAC, 48'd0);
                    cfg_write(R_OWN_MAC, 48'd0);
                end
                1:
                begin
                    cfg_write(R_RETRY_LIM, 48'd15);
                    cfg_write(R_AGE_LIMIT, 48'hFFFF_FFFF);
                    cfg_write(R_BCAST_MAC, 48'hFFFF_FFFF_FFFF);
                    cfg_write(R_OWN_MAC, 48'hFFFF_FFFF_FFFF);
                    cfg_write(R_IP_VALID, 48'd0);
                end
                2:
                begin
                    cfg_write(R_RETRY_LIM, 48'($urandom_range(1, 15)));
                    cfg_write(R_AGE_LIMIT, 48'd50);
                    cfg_write(R_IP_VALID, 48'd1);
                    cfg_write(R_OWN_IP, {16'h0, 32'hFFFF_FFFF});
                    cfg_write(R_SUBNET_BC, 48'd0);
                end
                3:
                begin
                    cfg_write(R_OWN_IP, {16'h0, ip_pool[$urandom_range(23)]});
                    cfg_write(R_SUBNET_BC, {16'h0, 32'hFFFF_FFFF});
                    cfg_write(R_BCAST_MAC, rand48());
                    cfg_write(R_OWN_MAC, rand48());
                    cfg_write(R_AGE_LIMIT, 48'd300);
                end
                4:
                begin
                    cfg_write(R_OWN_IP, 48'd0);
                    cfg_write(R_AGE_LIMIT, 48'($urandom));
                    cfg_write(R_RETRY_LIM, 48'd2);
                end
                default:
                begin
                    cfg_write(R_OWN_IP, {16'h0, 32'($urandom)});
                    cfg_write(R_SUBNET_BC, {16'h0, ip_pool[$urandom_range(23)]});
                    cfg_write(R_AGE_LIMIT, 48'd20);
                    cfg_write(R_RETRY_LIM, 48'd3);
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < PER_PHASE; n++)
            begin
                rand_request(ev);
                send_request(ev);
            end
            drain();
        end

        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ arp_cache_engine.f @@
rtl/ace_pkg.sv
rtl/ace_cell.sv
rtl/ace_ctrl.sv
rtl/arp_cache_engine.sv
rtl/ace_checker.sv
tb/arp_cache_checker.sv
tb/tb_arp_cache_engine.sv
